// ===== src/assert_macros.svh =====
// assertion macros shared by the checker modules
// needs clk and arst_n in the scope of the use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CAKX_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// checked at every edge, also during reset
`define CAKX_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// ===== src/cakx_pkg.sv =====
// shared types, constants and the rule table of the automaton keystream core
// no dependencies
package cakx_pkg;

	localparam int LANES = 8;
	localparam int CELLS = 64;
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	typedef logic [LANE_W-1:0] lane_idx_t;
	typedef logic [CELLS-1:0] cells_t;

	// control that every cell of the row sees
	typedef struct packed {
		logic      we;
		logic      load;
		lane_idx_t lane;
	} cakx_ctl_t;

	// rule byte picked by three bits of the previous cells
	function automatic logic [7:0] rule_byte(input logic [2:0] sel);
		logic [7:0] r;
		case (sel)
			3'd0: r = 8'h1E;
			3'd1: r = 8'h54;
			3'd2: r = 8'h5A;
			3'd3: r = 8'h65;
			3'd4: r = 8'h69;
			3'd5: r = 8'h96;
			3'd6: r = 8'h99;
			3'd7: r = 8'hA5;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/cakx_cell.sv =====
// one automaton cell: holds its bit of the current and previous cells of every lane
// depends on cakx_pkg
module cakx_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  cakx_pkg::cakx_ctl_t ctl,
	input  logic                seed,
	input  logic                cur_left,
	input  logic                cur_right,
	input  logic                prv_up1,
	input  logic                prv_up2,
	output logic                cur,
	output logic                prv,
	output logic                nxt
);

	logic [cakx_pkg::LANES-1:0] now_q;
	logic [cakx_pkg::LANES-1:0] before_q;
	logic [7:0]                 rule;
	logic [2:0]                 nb;

	// a load steps from the seed itself
	always_comb begin
		cur  = ctl.load ? seed : now_q[ctl.lane];
		prv  = ctl.load ? seed : before_q[ctl.lane];
		rule = cakx_pkg::rule_byte({prv_up2, prv_up1, prv});
		nb   = {cur_right, cur, cur_left};
		nxt  = rule[nb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			before_q <= '0;
		end else if (ctl.we) begin
			now_q[ctl.lane]    <= nxt;
			before_q[ctl.lane] <= cur;
		end
	end

endmodule

// ===== src/cakx_out.sv =====
// output register with one skid entry for the result channel
// depends on cakx_pkg
module cakx_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  cakx_pkg::cells_t res_data,
	input  logic             out_stall,
	output logic             out_valid,
	output cakx_pkg::cells_t data_out,
	output logic             full
);

	logic             out_valid_q;
	logic             skid_valid_q;
	cakx_pkg::cells_t data_q;
	cakx_pkg::cells_t skid_q;
	logic             out_fire;

	assign out_fire  = out_valid_q & ~out_stall;
	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				data_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_fire) begin
				data_q <= res_data;
			end else begin
				skid_q <= res_data;
			end
		end
	end

endmodule

// ===== src/cellular_automaton_keystream_xor_core.sv =====
// Keystream XOR core built from a row of 64 automaton cells shared by all lanes. A request
// is taken in every cycle (in_stall low); its lane steps within that cycle, so the next
// request may use the same lane at once, and an encrypt result is registered before it
// shows on data_out. A load request seeds the lane, runs one warm-up step and gives
// no result. Results pass through an output register and one skid entry; in_stall rises
// only when both hold results that the sink has not taken, so the rate is one request per
// cycle while out_stall stays low. Requests for a lane of LANES or above are dropped.
// depends on cakx_pkg, cakx_cell, cakx_out
module cellular_automaton_keystream_xor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [2:0]  lane,
	input  logic [63:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_out
);

	cakx_pkg::cakx_ctl_t          ctl;
	cakx_pkg::cells_t             cur_v;
	cakx_pkg::cells_t             prv_v;
	cakx_pkg::cells_t             nxt_v;
	logic [cakx_pkg::CELLS+1:0]   prv_ext;
	logic                         lane_ok;
	logic                         full;

	assign lane_ok  = 32'(lane) < cakx_pkg::LANES;
	assign in_stall = full;
	assign ctl.we   = in_valid & ~full & lane_ok;
	assign ctl.load = ~op;
	assign ctl.lane = cakx_pkg::lane_idx_t'(lane);

	// rule index bits above the top cell read as zero
	assign prv_ext = {2'b00, prv_v};

	for (genvar i = 0; i < cakx_pkg::CELLS; i++) begin : g_cell
		cakx_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.seed      (word[i]),
			.cur_left  (cur_v[(i + cakx_pkg::CELLS - 1) % cakx_pkg::CELLS]),
			.cur_right (cur_v[(i + 1) % cakx_pkg::CELLS]),
			.prv_up1   (prv_ext[i + 1]),
			.prv_up2   (prv_ext[i + 2]),
			.cur       (cur_v[i]),
			.prv       (prv_v[i]),
			.nxt       (nxt_v[i])
		);
	end

	cakx_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (ctl.we & op),
		.res_data  (word ^ nxt_v),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.data_out  (data_out),
		.full      (full)
	);

endmodule

// ===== src/cakx_checker.sv =====
// port-level checks of the keystream core, bound to the top level
// depends on cakx_pkg and assert_macros.svh
`include "assert_macros.svh"

module cakx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        op,
	input logic [2:0]  lane,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] data_out
);

	`CAKX_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(data_out))
	`CAKX_ASSERT(a_load_silent, in_valid && !in_stall && !op && !out_valid |=> !out_valid)
	`CAKX_ASSERT(a_enc_result, in_valid && !in_stall && op && !out_valid && (32'(lane) < cakx_pkg::LANES) |=> out_valid)
	`CAKX_ASSERT(a_stall_backlog, in_stall |-> out_valid)
	`CAKX_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid && !in_stall)

endmodule

bind cellular_automaton_keystream_xor_core cakx_checker u_cakx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.lane      (lane),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_out  (data_out)
);

// ===== verif/cellular_automaton_keystream_xor_core_tb.sv =====
// self-checking testbench for the cellular automaton keystream xor core
// predicts every lane's automaton state in plain SystemVerilog and checks each data_out
// depends on cakx_pkg and cellular_automaton_keystream_xor_core
module cellular_automaton_keystream_xor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_CRYPT = 1'b1;
	// rule bytes, entry k at bits 8k+7..8k
	localparam logic [63:0] CA_RULES = {8'hA5, 8'h99, 8'h96, 8'h69, 8'h65, 8'h5A, 8'h54, 8'h1E};

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_LOAD;
	logic [2:0]  lane = 3'd0;
	logic [63:0] word = 64'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] data_out;

	cakx_pkg::cells_t lane_now [cakx_pkg::LANES];
	cakx_pkg::cells_t lane_prev [cakx_pkg::LANES];
	logic [63:0] pending_data_out [$];
	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_left = 0;

	cellular_automaton_keystream_xor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.lane(lane),
		.word(word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one automaton step; neighbourhood wraps, rule select bits do not
	function automatic cakx_pkg::cells_t ca_next(input cakx_pkg::cells_t cur,
			input cakx_pkg::cells_t prev);
		cakx_pkg::cells_t nxt;
		cakx_pkg::cells_t shifted;
		logic [2:0] nb;
		logic [2:0] sel;
		logic [7:0] rb;
		for (int i = 0; i < 64; i++) begin
			nb = {cur[(i + 1) % 64], cur[i], cur[(i + 63) % 64]};
			shifted = prev >> i;
			sel = shifted[2:0];
			rb = CA_RULES[sel * 8 +: 8];
			nxt[i] = rb[nb];
		end
		return nxt;
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		case ($urandom_range(0, 9))
			0: w = 64'd0;
			1: w = '1;
			2: w = 64'd1 << $urandom_range(0, 63);
			3: w = ~(64'd1 << $urandom_range(0, 63));
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// update the lane state for an accepted request and queue its result
	task automatic predict_request(input logic o, input logic [2:0] l, input logic [63:0] w);
		cakx_pkg::cells_t nxt;
		if (l < cakx_pkg::LANES) begin
			if (o == OP_LOAD) begin
				lane_prev[l] = w;
				lane_now[l] = ca_next(w, w);
			end else begin
				nxt = ca_next(lane_now[l], lane_prev[l]);
				lane_prev[l] = lane_now[l];
				lane_now[l] = nxt;
				pending_data_out.push_back(w ^ nxt);
			end
		end
	endtask

	task automatic send_request(input logic o, input logic [2:0] l, input logic [63:0] w);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		lane <= l;
		word <= w;
		do @(posedge clk); while (in_stall);
		predict_request(o, l, w);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_data_out.size() != 0);
	endtask

	// sink side: random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		logic [63:0] exp_word;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_data_out.size() == 0) begin
				$error("data_out with no request waiting: actual %h", data_out);
				mismatch_count++;
			end else begin
				exp_word = pending_data_out.pop_front();
				if (data_out !== exp_word) begin
					$error("data_out mismatch: expected %h, actual %h", exp_word, data_out);
					mismatch_count++;
				end
			end
		end
	end

	// lanes never loaded still hold zero cells
	task automatic test_reset_state();
		for (int l = 0; l < cakx_pkg::LANES; l++)
			send_request(OP_CRYPT, l[2:0], l[0] ? '1 : 64'd0);
	endtask

	task automatic test_edge_cases();
		// single cells at both ends exercise the wrap of the neighbourhood
		send_request(OP_LOAD, 3'd0, 64'd1);
		send_request(OP_CRYPT, 3'd0, 64'd0);
		send_request(OP_LOAD, 3'd7, 64'h8000_0000_0000_0000);
		send_request(OP_CRYPT, 3'd7, '1);
		send_request(OP_LOAD, 3'd1, '1);
		send_request(OP_CRYPT, 3'd1, 64'd0);
		send_request(OP_CRYPT, 3'd1, '1);
		send_request(OP_LOAD, 3'd2, 64'd0);
		send_request(OP_CRYPT, 3'd2, 64'hA5A5_5A5A_0F0F_F0F0);
		send_request(OP_LOAD, 3'd3, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_CRYPT, 3'd3, 64'h5555_5555_5555_5555);
		send_request(OP_LOAD, 3'd4, 64'h8000_0000_0000_0001);
		send_request(OP_CRYPT, 3'd4, 64'h0123_4567_89AB_CDEF);
		// top bits of previous cells select rules with zeros shifted in
		send_request(OP_LOAD, 3'd5, 64'hE000_0000_0000_0000);
		send_request(OP_CRYPT, 3'd5, 64'd0);
		send_request(OP_CRYPT, 3'd5, 64'd0);
		// reload a lane that is already running
		send_request(OP_LOAD, 3'd0, 64'h7FFF_FFFF_FFFF_FFFE);
		send_request(OP_CRYPT, 3'd0, '1);
		send_request(OP_LOAD, 3'd6, 64'hFEDC_BA98_7654_3210);
		send_request(OP_LOAD, 3'd6, 64'h0000_0000_FFFF_FFFF);
		send_request(OP_CRYPT, 3'd6, 64'hFFFF_FFFF_0000_0000);
	endtask

	// mostly encrypts over random lanes, with occasional reseeding
	task automatic test_interleaved_lanes(input int count);
		for (int n = 0; n < count; n++)
			send_request(($urandom_range(0, 99) < 85) ? OP_CRYPT : OP_LOAD,
				3'($urandom_range(0, 7)), rand_word());
	endtask

	// seed one lane, then run a stream of words through it, back to back unless idle_pct is set
	task automatic test_lane_streams(input int streams);
		logic [2:0] l;
		for (int s = 0; s < streams; s++) begin
			l = 3'($urandom_range(0, 7));
			send_request(OP_LOAD, l, rand_word());
			repeat ($urandom_range(2, 12)) send_request(OP_CRYPT, l, rand_word());
		end
	endtask

	task automatic test_random_ops(input int count);
		for (int n = 0; n < count; n++)
			send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), {$urandom, $urandom});
	endtask

	initial begin
		arst_n <= 1'b0;
		for (int l = 0; l < cakx_pkg::LANES; l++) begin
			lane_now[l] = '0;
			lane_prev[l] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 25;
		test_reset_state();
		test_edge_cases();
		test_interleaved_lanes(150);
		wait_for_results();
		idle_pct = 0;
		test_lane_streams(12);
		idle_pct = 40;
		test_lane_streams(12);
		test_interleaved_lanes(150);
		idle_pct = 10;
		test_random_ops(60);
		// no idling on either side from here on
		idle_pct = 0;
		test_interleaved_lanes(120);
		in_valid <= 1'b0;
		while (pending_data_out.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/cakx_pkg.sv
src/cakx_cell.sv
src/cakx_out.sv
src/cellular_automaton_keystream_xor_core.sv
src/cakx_checker.sv
verif/cellular_automaton_keystream_xor_core_tb.sv
